@@ design/kcd_pkg.sv @@
// ----------------------------------------------------------------------------
// kcd_pkg: shared types and constants of the key click detector
// Register indexes, event codes, phase encoding and the configuration set.
// ----------------------------------------------------------------------------
package kcd_pkg;

	localparam int FILT_W = 8;
	localparam int TMR_W  = 16;
	localparam int CLK_W  = 2;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_FILTER_TICKS = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_TICKS   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MULTI_TICKS  = 2'd2;

	localparam logic [FILT_W-1:0] FILTER_TICKS_RST = 8'd4;
	localparam logic [TMR_W-1:0]  LONG_TICKS_RST   = 16'd600;
	localparam logic [TMR_W-1:0]  MULTI_TICKS_RST  = 16'd60;

	localparam logic [CLK_W-1:0] CLICKS_FOR_DOUBLE = 2'd2;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	typedef enum logic [6:0] {
		PH_WAIT_RELEASE = 7'b0000001,
		PH_IDLE         = 7'b0000010,
		PH_PRESS_FILT   = 7'b0000100,
		PH_PRESSED      = 7'b0001000,
		PH_LONG         = 7'b0010000,
		PH_REL_FILT     = 7'b0100000,
		PH_WINDOW       = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [FILT_W-1:0] filter_ticks;
		logic [TMR_W-1:0]  long_ticks;
		logic [TMR_W-1:0]  multi_ticks;
	} cfg_t;

	function automatic logic [FILT_W-1:0] min1_filt(input logic [FILT_W-1:0] v);
		return (v == '0) ? FILT_W'(1) : v;
	endfunction

	function automatic logic [TMR_W-1:0] min1_tmr(input logic [TMR_W-1:0] v);
		return (v == '0) ? TMR_W'(1) : v;
	endfunction

endpackage

@@ design/key_click_double_long_detector.sv @@
// ----------------------------------------------------------------------------
// key_click_double_long_detector: debounced click, double click, long press
//
// Each input item is one tick of the raw key level (key_level). For every
// item exactly one result item leaves on the output channel: event_code
// (0 none, 1 single click, 2 double click, 3 long press) and key_down, the
// debounced pressed level after that tick.
// Items are taken when in_valid is high and in_stall is low; results leave
// when out_valid is high and out_stall is low.
// An accepted item is registered in the input stage, then its result in the
// result register, where out_valid rises; a stall can hold it in between.
// One item per cycle is sustained while the output is not stalled. A stalled
// output holds its result; the input register keeps taking items until it is
// also occupied, then in_stall rises. Thresholds are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data (0 filter_ticks, 1 long_ticks,
// 2 multi_ticks); the user must write them only while no item is in flight;
// the block does not enforce it. Reset empties the pipeline, loads thresholds
// 4, 600 and 60, and leaves the machine waiting for a debounced release.
// ----------------------------------------------------------------------------
module key_click_double_long_detector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        key_level,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  event_code,
	output logic                        key_down,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kcd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [kcd_pkg::TMR_W-1:0]   cfg_data
);

	kcd_pkg::cfg_t      cfg_q;
	kcd_pkg::event_t    fsm_ev;
	logic               fsm_down;
	logic               valid_s1, level_s1;
	logic               out_valid_q, key_down_q;
	logic [1:0]         event_code_q;
	logic               advance, step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_ticks <= kcd_pkg::FILTER_TICKS_RST;
			cfg_q.long_ticks   <= kcd_pkg::LONG_TICKS_RST;
			cfg_q.multi_ticks  <= kcd_pkg::MULTI_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kcd_pkg::REG_FILTER_TICKS: cfg_q.filter_ticks <= cfg_data[kcd_pkg::FILT_W-1:0];
				kcd_pkg::REG_LONG_TICKS:   cfg_q.long_ticks   <= cfg_data;
				kcd_pkg::REG_MULTI_TICKS:  cfg_q.multi_ticks  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// hold the input item until the result register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= key_level;
		end
	end

	kcd_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (level_s1),
		.cfg    (cfg_q),
		.ev     (fsm_ev),
		.down   (fsm_down)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_code_q <= fsm_ev;
			key_down_q   <= fsm_down;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_code_q;
	assign key_down   = key_down_q;

endmodule

@@ design/kcd_fsm.sv @@
// ----------------------------------------------------------------------------
// kcd_fsm: key phase machine with debounce counter and hold/window timer
// Advances by one tick per step and gives the event and debounced level.
// ----------------------------------------------------------------------------
module kcd_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                level,
	input  kcd_pkg::cfg_t       cfg,
	output kcd_pkg::event_t     ev,
	output logic                down
);

	kcd_pkg::phase_t                ph_q, ph_d;
	logic [kcd_pkg::FILT_W-1:0]     fc_q, fc_d, fc_inc;
	logic [kcd_pkg::TMR_W-1:0]      tmr_q, tmr_d, tmr_inc, tmr_lim;
	logic [kcd_pkg::CLK_W-1:0]      clicks_q, clicks_d, clicks_inc;
	logic                           long_q, long_d;
	logic                           down_q, down_d;
	logic                           fc_hit, tmr_hit;

	assign fc_inc     = (fc_q == '1) ? fc_q : fc_q + kcd_pkg::FILT_W'(1);
	assign fc_hit     = fc_inc >= kcd_pkg::min1_filt(cfg.filter_ticks);
	assign tmr_inc    = (tmr_q == '1) ? tmr_q : tmr_q + kcd_pkg::TMR_W'(1);
	assign tmr_lim    = (ph_q == kcd_pkg::PH_WINDOW) ? cfg.multi_ticks : cfg.long_ticks;
	assign tmr_hit    = tmr_inc >= kcd_pkg::min1_tmr(tmr_lim);
	assign clicks_inc = clicks_q + kcd_pkg::CLK_W'(1);

	always_comb begin
		ph_d     = ph_q;
		fc_d     = fc_q;
		tmr_d    = tmr_q;
		clicks_d = clicks_q;
		long_d   = long_q;
		down_d   = down_q;
		ev       = kcd_pkg::EV_NONE;
		case (ph_q)
			kcd_pkg::PH_WAIT_RELEASE: begin
				if (level) begin
					fc_d = '0;
				end else if (fc_hit) begin
					fc_d   = '0;
					down_d = 1'b0;
					ph_d   = kcd_pkg::PH_IDLE;
				end else begin
					fc_d = fc_inc;
				end
			end
			kcd_pkg::PH_IDLE: begin
				if (level) begin
					fc_d = '0;
					ph_d = kcd_pkg::PH_PRESS_FILT;
				end
			end
			kcd_pkg::PH_PRESS_FILT: begin
				if (!level) begin
					ph_d = (clicks_q != '0) ? kcd_pkg::PH_WINDOW : kcd_pkg::PH_IDLE;
				end else begin
					fc_d = fc_inc;
					if (fc_hit) begin
						down_d = 1'b1;
						long_d = 1'b0;
						tmr_d  = '0;
						ph_d   = kcd_pkg::PH_PRESSED;
					end
				end
			end
			kcd_pkg::PH_PRESSED: begin
				if (!level) begin
					fc_d = '0;
					ph_d = kcd_pkg::PH_REL_FILT;
				end else begin
					tmr_d = tmr_inc;
					if (tmr_hit) begin
						long_d   = 1'b1;
						clicks_d = '0;
						ph_d     = kcd_pkg::PH_LONG;
						ev       = kcd_pkg::EV_LONG;
					end
				end
			end
			kcd_pkg::PH_LONG: begin
				if (!level) begin
					fc_d = '0;
					ph_d = kcd_pkg::PH_REL_FILT;
				end
			end
			kcd_pkg::PH_REL_FILT: begin
				if (level) begin
					ph_d = long_q ? kcd_pkg::PH_LONG : kcd_pkg::PH_PRESSED;
				end else begin
					fc_d = fc_inc;
					if (fc_hit) begin
						down_d = 1'b0;
						if (long_q) begin
							long_d   = 1'b0;
							clicks_d = '0;
							ph_d     = kcd_pkg::PH_IDLE;
						end else if (clicks_inc >= kcd_pkg::CLICKS_FOR_DOUBLE) begin
							clicks_d = '0;
							ph_d     = kcd_pkg::PH_IDLE;
							ev       = kcd_pkg::EV_DOUBLE;
						end else begin
							clicks_d = clicks_inc;
							tmr_d    = '0;
							ph_d     = kcd_pkg::PH_WINDOW;
						end
					end
				end
			end
			kcd_pkg::PH_WINDOW: begin
				if (level) begin
					fc_d = '0;
					ph_d = kcd_pkg::PH_PRESS_FILT;
				end else begin
					tmr_d = tmr_inc;
					if (tmr_hit) begin
						clicks_d = '0;
						ph_d     = kcd_pkg::PH_IDLE;
						ev       = kcd_pkg::EV_SINGLE;
					end
				end
			end
			default: begin
				ph_d = kcd_pkg::PH_IDLE;
			end
		endcase
	end

	assign down = down_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= kcd_pkg::PH_WAIT_RELEASE;
			fc_q     <= '0;
			tmr_q    <= '0;
			clicks_q <= '0;
			long_q   <= 1'b0;
			down_q   <= 1'b0;
		end else if (step) begin
			ph_q     <= ph_d;
			fc_q     <= fc_d;
			tmr_q    <= tmr_d;
			clicks_q <= clicks_d;
			long_q   <= long_d;
			down_q   <= down_d;
		end
	end

endmodule

@@ design/kcd_checker.sv @@
// ----------------------------------------------------------------------------
// kcd_checker: port-level checks of the key click detector
// Watches handshakes and the consistency of events with the key level.
// ----------------------------------------------------------------------------
module kcd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  event_code,
	input logic                        key_down
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(key_down))
		else $error("stalled result changed");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_click_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code == kcd_pkg::EV_SINGLE || event_code == kcd_pkg::EV_DOUBLE)
		|-> !key_down)
		else $error("click reported while key down");

	a_long_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == kcd_pkg::EV_LONG |-> key_down)
		else $error("long press reported while key up");

endmodule

bind key_click_double_long_detector kcd_checker u_kcd_checker (.*);

@@ tb/sv/key_click_double_long_detector_test.sv @@
// ----------------------------------------------------------------------------
// key_click_double_long_detector_test: self-checking bench for the key detector
// Feeds raw key ticks through the valid/stall handshake with random gaps and
// output stalls, tracks the debounce machine tick by tick, and compares every
// result item field by field. A short script covers power-up release, bounces
// and each event, then random gestures run under several threshold sets,
// among them the narrowest, and plain key holds run under the widest.
// ----------------------------------------------------------------------------
module key_click_double_long_detector_test;
	import kcd_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT      = 1000;
	localparam int HOLD_OFF_CYCLES = 40;
	localparam int SCRIPT_LEN      = 33;

	typedef struct packed {
		event_t ev;
		logic   dn;
	} tick_result_t;

	typedef struct {
		bit               wr;
		logic [IDX_W-1:0] idx;
		logic [TMR_W-1:0] data;
		logic             lvl;
		bit               typed;
		event_t           ev;
		logic             dn;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                key_level;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          event_code;
	logic                key_down;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [TMR_W-1:0]    cfg_data;

	phase_t              ph;
	logic [FILT_W-1:0]   deb_count;
	logic [CLK_W-1:0]    click_count;
	logic                long_held;
	logic                down_level;
	logic [TMR_W-1:0]    span_timer;
	cfg_t                thresholds;

	tick_result_t        awaited[$];
	int                  keys_sent;
	int                  results_seen;
	int                  mismatches;
	bit                  steady_mode;
	bit                  hold_req;

	script_row_t script [SCRIPT_LEN] = '{
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b1, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b1, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b1, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b1, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b1, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b1, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b1, EV_NONE, 1'b0},
		'{1'b1, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b1, REG_LONG_TICKS,   16'd1, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b1, REG_MULTI_TICKS,  16'd2, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b1, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0},
		'{1'b0, REG_FILTER_TICKS, 16'd0, 1'b0, 1'b0, EV_NONE, 1'b0}
	};

	key_click_double_long_detector uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit debounce_done();
		if (deb_count != 8'hFF)
			deb_count++;
		return deb_count >= ((thresholds.filter_ticks == 0) ? 8'd1 : thresholds.filter_ticks);
	endfunction

	function automatic bit timer_done(input logic [TMR_W-1:0] limit);
		if (span_timer != 16'hFFFF)
			span_timer++;
		return span_timer >= ((limit == 0) ? 16'd1 : limit);
	endfunction

	task automatic predict_tick(input logic lvl, output event_t ev, output logic dn);
		ev = EV_NONE;
		case (ph)
			PH_WAIT_RELEASE: begin
				if (lvl)
					deb_count = '0;
				else if (debounce_done()) begin
					deb_count = '0;
					down_level = 1'b0;
					ph = PH_IDLE;
				end
			end
			PH_IDLE: begin
				if (lvl) begin
					deb_count = '0;
					ph = PH_PRESS_FILT;
				end
			end
			PH_PRESS_FILT: begin
				if (!lvl)
					ph = (click_count != 0) ? PH_WINDOW : PH_IDLE;
				else if (debounce_done()) begin
					down_level = 1'b1;
					long_held = 1'b0;
					span_timer = '0;
					ph = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!lvl) begin
					deb_count = '0;
					ph = PH_REL_FILT;
				end else if (timer_done(thresholds.long_ticks)) begin
					long_held = 1'b1;
					click_count = '0;
					ph = PH_LONG;
					ev = EV_LONG;
				end
			end
			PH_LONG: begin
				if (!lvl) begin
					deb_count = '0;
					ph = PH_REL_FILT;
				end
			end
			PH_REL_FILT: begin
				if (lvl)
					ph = long_held ? PH_LONG : PH_PRESSED;
				else if (debounce_done()) begin
					down_level = 1'b0;
					if (long_held) begin
						long_held = 1'b0;
						click_count = '0;
						ph = PH_IDLE;
					end else begin
						click_count++;
						if (click_count >= CLICKS_FOR_DOUBLE) begin
							click_count = '0;
							ph = PH_IDLE;
							ev = EV_DOUBLE;
						end else begin
							span_timer = '0;
							ph = PH_WINDOW;
						end
					end
				end
			end
			PH_WINDOW: begin
				if (lvl) begin
					deb_count = '0;
					ph = PH_PRESS_FILT;
				end else if (timer_done(thresholds.multi_ticks)) begin
					click_count = '0;
					ph = PH_IDLE;
					ev = EV_SINGLE;
				end
			end
			default: ph = PH_IDLE;
		endcase
		dn = down_level;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at result %0d: %s got %0h expected %0h",
			results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic send_key(input logic lvl, input bit typed, input event_t t_ev,
			input logic t_dn);
		tick_result_t want;
		event_t ev;
		logic dn;
		if (!steady_mode && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		key_level <= lvl;
		do @(posedge clk); while (in_stall);
		predict_tick(lvl, ev, dn);
		want.ev = typed ? t_ev : ev;
		want.dn = typed ? t_dn : dn;
		awaited.push_back(want);
		keys_sent++;
		@(negedge clk);
	endtask

	task automatic hold_key(input logic lvl, input int n);
		repeat (n) send_key(lvl, 1'b0, EV_NONE, 1'b0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [IDX_W-1:0] idx, input logic [TMR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FILTER_TICKS: thresholds.filter_ticks = data[FILT_W-1:0];
			REG_LONG_TICKS:   thresholds.long_ticks = data;
			REG_MULTI_TICKS:  thresholds.multi_ticks = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic play_gesture();
		int fl, ln, ml;
		fl = (thresholds.filter_ticks == 0) ? 1 : thresholds.filter_ticks;
		ln = (thresholds.long_ticks == 0) ? 1 : thresholds.long_ticks;
		ml = (thresholds.multi_ticks == 0) ? 1 : thresholds.multi_ticks;
		case ($urandom_range(0, 7))
			0: repeat ($urandom_range(1, 8))
				send_key(1'($urandom_range(0, 1)), 1'b0, EV_NONE, 1'b0);
			1: hold_key(1'b1, fl + ln + $urandom_range(0, 4));
			2: hold_key(1'b1, $urandom_range(1, fl));
			default: hold_key(1'b1, $urandom_range(1, fl + ln + 1));
		endcase
		hold_key(1'b0, $urandom_range(1, fl + ml + 3));
	endtask

	task automatic random_thresholds();
		write_threshold(REG_FILTER_TICKS, 16'($urandom_range(0, 5)));
		write_threshold(REG_LONG_TICKS, 16'($urandom_range(1, 40)));
		write_threshold(REG_MULTI_TICKS, 16'($urandom_range(0, 25)));
	endtask

	always @(posedge clk) begin : check_results
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0)
				report_mismatch("result with none awaited", 16'(event_code), 16'h0);
			else begin
				want = awaited.pop_front();
				if (event_code !== want.ev)
					report_mismatch("event_code", 16'(event_code), 16'(want.ev));
				if (key_down !== want.dn)
					report_mismatch("key_down", 16'(key_down), 16'(want.dn));
			end
			results_seen++;
		end
	end

	initial begin : receiver
		bit held_off;
		held_off = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && hold_req) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!steady_mode && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("** key_click_double_long_detector: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int first;
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_level = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FILTER_TICKS;
		cfg_data = '0;
		steady_mode = 1'b0;
		hold_req = 1'b0;
		keys_sent = 0;
		results_seen = 0;
		mismatches = 0;
		ph = PH_WAIT_RELEASE;
		deb_count = '0;
		click_count = '0;
		long_held = 1'b0;
		down_level = 1'b0;
		span_timer = '0;
		thresholds = '{filter_ticks: FILTER_TICKS_RST, long_ticks: LONG_TICKS_RST,
			multi_ticks: MULTI_TICKS_RST};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].wr) begin
				settle();
				write_threshold(script[i].idx, script[i].data);
			end else
				send_key(script[i].lvl, script[i].typed, script[i].ev, script[i].dn);
		end

		repeat (4) begin
			settle();
			random_thresholds();
			first = keys_sent;
			while (keys_sent - first < 45) play_gesture();
		end

		// widest thresholds: hold the receiver off while keys keep coming, end mid-count
		settle();
		write_threshold(REG_FILTER_TICKS, 16'hFFFF);
		write_threshold(REG_LONG_TICKS, 16'hFFFF);
		write_threshold(REG_MULTI_TICKS, 16'hFFFF);
		write_threshold(REG_SPARE, 16'hA5A5);
		hold_req = 1'b1;
		hold_key(1'b0, 30);
		hold_key(1'b1, 40);

		// lower thresholds under a running count
		settle();
		write_threshold(REG_LONG_TICKS, 16'd1);
		write_threshold(REG_FILTER_TICKS, 16'd1);
		write_threshold(REG_MULTI_TICKS, 16'd1);
		hold_key(1'b1, 3);
		first = keys_sent;
		while (keys_sent - first < 30) play_gesture();

		settle();
		steady_mode = 1'b1;
		random_thresholds();
		first = keys_sent;
		while (keys_sent - first < 40) play_gesture();
		settle();

		if (mismatches == 0)
			$display("** key_click_double_long_detector: PASSED **");
		else
			$display("** key_click_double_long_detector: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
design/kcd_pkg.sv
design/kcd_fsm.sv
design/key_click_double_long_detector.sv
design/kcd_checker.sv
tb/sv/key_click_double_long_detector_test.sv
